// File: rtl/core/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; imported by every module of the block.
package isort_pkg;

  localparam int unsigned VALUE_W = 8;
  localparam int unsigned SHIFT_W = 7;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 7'd127;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               final_item;
  } item_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_of_run;
    logic [SHIFT_W-1:0] shift_total;
    logic               overflowed;
  } result_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_EMIT
  } isort_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } isort_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last_one;
  } isort_stat_t;

endpackage

// File: rtl/core/isort_datapath.sv
// Register-chain datapath of the insertion sorter: parallel compare and shift,
// shift counting and shift-down emission. Depends on isort_pkg.
module isort_datapath import isort_pkg::*; #(
  parameter int unsigned COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  isort_cmd_t         cmd,
  input  logic [VALUE_W-1:0] value,
  output isort_stat_t        stat,
  output result_word_t       head
);

  localparam int unsigned FW = $clog2(COUNT + 1);

  logic [VALUE_W-1:0] store [COUNT];
  logic [FW-1:0]      fill;
  logic [SHIFT_W-1:0] shift_acc;
  logic [SHIFT_W-1:0] delta;
  logic               delta_pend;
  logic               ovf;

  logic [COUNT-1:0]   gt;
  logic [COUNT-1:0]   at_pos;
  logic [FW-1:0]      pos;
  logic               full;
  logic [SHIFT_W:0]   acc_sum;

  assign full = (fill == FW'(COUNT));

  // Entries above the new value form a suffix of the filled region.
  always_comb begin
    pos = '0;
    for (int i = 0; i < COUNT; i++) begin
      gt[i] = (FW'(i) < fill) && (store[i] > value);
    end
    for (int i = 0; i < COUNT; i++) begin
      if (i == 0) begin
        at_pos[i] = gt[i] || (fill == '0);
      end else begin
        at_pos[i] = !gt[i-1] && (gt[i] || (fill == FW'(i)));
      end
    end
    for (int i = 0; i < COUNT; i++) begin
      if (at_pos[i]) begin
        pos = pos | FW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      for (int i = 0; i < COUNT; i++) begin
        if (at_pos[i]) begin
          store[i] <= value;
        end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          store[i] <= store[(i > 0) ? i - 1 : 0];
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < COUNT - 1; i++) begin
        store[i] <= store[i+1];
      end
    end
  end

  // Fold the shift count of the previous insert into the accumulator in the cycle after it.
  assign acc_sum = {1'b0, shift_acc} + {1'b0, delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      shift_acc  <= '0;
      delta      <= '0;
      delta_pend <= 1'b0;
      ovf        <= 1'b0;
    end else begin
      delta_pend <= cmd.insert && !full;
      if (delta_pend) begin
        shift_acc <= acc_sum[SHIFT_W] ? SHIFT_MAX : acc_sum[SHIFT_W-1:0];
      end
      if (cmd.insert) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          fill  <= fill + FW'(1);
          delta <= SHIFT_W'(fill - pos);
        end
      end else if (cmd.clear) begin
        fill      <= '0;
        shift_acc <= '0;
        ovf       <= 1'b0;
      end else if (cmd.pop) begin
        fill <= fill - FW'(1);
      end
    end
  end

  assign stat.last_one = (fill == FW'(1));

  always_comb begin
    head.sorted_value = store[0];
    head.last_of_run  = stat.last_one;
    head.shift_total  = stat.last_one ? shift_acc : '0;
    head.overflowed   = stat.last_one ? ovf : 1'b0;
  end

endmodule

// File: rtl/core/isort_ctrl.sv
// Controller of the insertion sorter: load, settle and emit phases.
// Depends on isort_pkg.
module isort_ctrl import isort_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_final,
  input  logic        result_ready,
  input  isort_stat_t stat,
  output logic        item_ready,
  output logic        result_valid,
  output isort_cmd_t  cmd
);

  isort_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    cmd          = '0;
    case (state)
      ST_LOAD: begin
        // hold off the item channel while reset is applied
        item_ready = !rst;
        if (item_valid && !rst) begin
          cmd.insert = 1'b1;
          if (item_final) begin
            state_next = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        // let the last shift count land in the accumulator
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        result_valid = 1'b1;
        if (result_ready) begin
          cmd.pop = 1'b1;
          if (stat.last_one) begin
            cmd.clear  = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/core/insertion_sorter.sv
// Top level of the insertion sorter: controller plus register-chain datapath.
// Depends on isort_pkg, isort_ctrl and isort_datapath.
//
// Block insertion sorter for unsigned 8-bit values. Each accepted word on the
// item channel is inserted into an ascending chain of COUNT registers: every
// stored value strictly greater than the new one moves up a place, equal
// values keep arrival order, and the number of moves is added to a shift
// total that saturates at 127. A word arriving while the chain is full is
// dropped and the overflow flag is set. The word flagged final_item (itself
// inserted if there is room) closes the block: item_ready drops, a settle
// state folds in the last shift count, then the stored values leave on the
// result channel in ascending order, one word per cycle while result_ready is
// high, by shifting the chain down. The last result word carries last_of_run,
// the shift total and the overflow flag; these are zero on earlier words.
// After the last result is taken the block is empty and item_ready rises
// again. A block of n stored values passes through the settle state and n
// emissions after loading, during which no item is taken.
module insertion_sorter import isort_pkg::*; #(
  parameter int unsigned COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  item_word_t   item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  isort_cmd_t  cmd;
  isort_stat_t stat;

  // Sequence the load and emit phases.
  isort_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_final   (item.final_item),
    .result_ready (result_ready),
    .stat         (stat),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  // Hold the sorted chain and counters; the chain head is the result word.
  isort_datapath #(
    .COUNT (COUNT)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .value (item.value),
    .stat  (stat),
    .head  (result)
  );

endmodule

// File: rtl/core/isort_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on isort_pkg and insertion_sorter.
module isort_checker import isort_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_ready,
  input item_word_t   item,
  input logic         result_valid,
  input logic         result_ready,
  input result_word_t result
);

  // Load and emit phases never overlap.
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("item_ready and result_valid both high");

  // A final word closes the block: the settle state follows, with both sides quiet.
  a_settle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.final_item) |=> (!item_ready && !result_valid))
    else $error("no settle cycle after final word");

  // The last result reopens the item channel.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.last_of_run) |=> item_ready)
    else $error("item channel not reopened after last result");

  // Totals travel only on the last word.
  a_totals: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last_of_run) |->
      (result.shift_total == '0 && !result.overflowed))
    else $error("totals on a non-last result word");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

// File: tb/sv/sorted_run_checker.sv
`timescale 1ns / 100ps
// Checker for insertion_sorter: watches the item and result channels, keeps its
// own copy of the sorted run and compares every result word with it.
// Depends on isort_pkg.
module sorted_run_checker import isort_pkg::*; #(
  parameter int unsigned COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_ready,
  input  item_word_t   item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_word_t result,
  output int           mismatches,
  output int           awaiting,
  output int           runs_closed,
  output int           words_checked,
  output int           overflow_runs
);

  logic [VALUE_W-1:0] run_values [COUNT];
  int unsigned        run_fill;
  logic [SHIFT_W-1:0] run_shifts;
  logic               run_dropped;
  result_word_t       sorted_words [$];

  // Insert one value; larger stored values move up, equal ones stay below.
  function automatic void insert_value(input logic [VALUE_W-1:0] v);
    int unsigned slot;
    slot = run_fill;
    while (slot > 0 && run_values[slot-1] > v) begin
      run_values[slot] = run_values[slot-1];
      slot--;
      if (run_shifts != SHIFT_MAX) run_shifts++;
    end
    run_values[slot] = v;
    run_fill++;
  endfunction

  always @(posedge clk) begin
    result_word_t want;
    logic         bad;
    if (rst) begin
      run_fill      = 0;
      run_shifts    = '0;
      run_dropped   = 1'b0;
      mismatches    = 0;
      runs_closed   = 0;
      words_checked = 0;
      overflow_runs = 0;
      sorted_words.delete();
    end else begin
      if (result_valid && result_ready) begin
        words_checked++;
        if (sorted_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word value=%0d last=%0b shifts=%0d ovf=%0b",
                   $time, result.sorted_value, result.last_of_run,
                   result.shift_total, result.overflowed);
        end else begin
          want = sorted_words.pop_front();
          bad  = (result.sorted_value !== want.sorted_value) ||
                 (result.last_of_run  !== want.last_of_run)  ||
                 (result.shift_total  !== want.shift_total)  ||
                 (result.overflowed   !== want.overflowed);
          if (bad) begin
            mismatches++;
            $display("%0t: result mismatch expected value=%0d last=%0b shifts=%0d ovf=%0b",
                     $time, want.sorted_value, want.last_of_run,
                     want.shift_total, want.overflowed);
            $display("%0t:                 actual   value=%0d last=%0b shifts=%0d ovf=%0b",
                     $time, result.sorted_value, result.last_of_run,
                     result.shift_total, result.overflowed);
          end
        end
      end
      if (item_valid && item_ready) begin
        if (run_fill < COUNT) insert_value(item.value);
        else run_dropped = 1'b1;
        if (item.final_item) begin
          for (int k = 0; k < run_fill; k++) begin
            want.sorted_value = run_values[k];
            want.last_of_run  = (k == run_fill - 1);
            want.shift_total  = want.last_of_run ? run_shifts : '0;
            want.overflowed   = want.last_of_run ? run_dropped : 1'b0;
            sorted_words.push_back(want);
          end
          runs_closed++;
          if (run_dropped) overflow_runs++;
          run_fill    = 0;
          run_shifts  = '0;
          run_dropped = 1'b0;
        end
      end
    end
    awaiting = sorted_words.size();
  end

endmodule

// File: tb/sv/tb_insertion_sorter.sv
`timescale 1ns / 100ps
// Top of the insertion_sorter testbench: clock, reset, item and result drivers.
// Depends on isort_pkg, insertion_sorter and sorted_run_checker.
module tb_insertion_sorter;
  import isort_pkg::*;

  localparam int unsigned COUNT = 16;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned ITEM_TARGET = 200;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_ready;
  item_word_t   item;
  logic         result_valid;
  logic         result_ready;
  result_word_t result;

  int mismatches;
  int awaiting;
  int runs_closed;
  int words_checked;
  int overflow_runs;

  // Shared between the item and result drivers. steady suppresses new random
  // idling on both sides (hold-offs and stalls under way still run); each bump
  // of hold_requests asks the result driver for one long hold-off.
  bit steady        = 1'b0;
  int hold_requests = 0;
  int words_sent    = 0;

  insertion_sorter #(.COUNT(COUNT)) uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  sorted_run_checker #(.COUNT(COUNT)) run_check (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .runs_closed   (runs_closed),
    .words_checked (words_checked),
    .overflow_runs (overflow_runs)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL insertion_sorter");
    $finish;
  end

  // Idle length before the next item word: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Offer one item word. Called and returning at a falling edge; valid stays
  // high into the next call, so back-to-back words need no extra assignment.
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       = '{value: v, final_item: fin};
    item_valid = 1'b1;
    // Hold the word until the rising edge that accepts it.
    do @(posedge clk); while (!item_ready);
    words_sent++;
    @(negedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  // The hold-off is counted here so it runs while the item driver keeps
  // offering words, letting the block fill up and, once closed, keep item_ready low.
  initial begin
    int hold_left;
    int stall_left;
    int seen_requests;
    hold_left     = 0;
    stall_left    = 0;
    seen_requests = 0;
    result_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen_requests) begin
        seen_requests = hold_requests;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_ready = 1'b0;
        stall_left--;
      end else if (steady || $urandom_range(0, 99) < 65) begin
        result_ready = 1'b1;
      end else begin
        result_ready = 1'b0;
        stall_left   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 40);
      end
    end
  end

  initial begin
    int run_len;
    int lo;
    int hi;
    int run_no;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed runs. A run of one word, smallest value.
    send_word(8'd0, 1'b1);
    // Duplicates around a smaller value: equal words keep arrival order.
    send_word(8'd128, 1'b0);
    send_word(8'd5, 1'b0);
    send_word(8'd128, 1'b1);
    // Strictly descending full run from 255 down to 0: every insert shifts the
    // whole store, giving the largest total of 120. Two more words follow
    // into a full store and are dropped, the second one being the final word,
    // which must still close the run with the overflow flag set. Hold the
    // result side off meanwhile and keep sending so the input stalls.
    steady = 1'b1;
    hold_requests++;
    for (int k = 0; k < COUNT; k++) send_word(8'(255 - 17 * k), 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b1);
    steady = 1'b0;

    // Random runs: mostly up to COUNT long, some short, some overrunning the
    // store. Half draw from a narrow window so duplicates are common.
    run_no = 0;
    while (words_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1:    run_len = $urandom_range(1, 3);
        2:       run_len = COUNT + $urandom_range(1, 4);
        default: run_len = $urandom_range(1, COUNT);
      endcase
      if ($urandom_range(0, 1)) begin
        lo = 0;
        hi = 255;
      end else begin
        lo = $urandom_range(0, 250);
        hi = lo + 5;
      end
      steady = ($urandom_range(0, 5) == 0);
      if (run_no == 5) hold_requests++;
      for (int k = 0; k < run_len; k++)
        send_word(8'($urandom_range(hi, lo)), k == run_len - 1);
      run_no++;
    end
    item_valid = 1'b0;
    steady     = 1'b0;

    // Drain the outstanding result words, then let the pipe settle.
    while (awaiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d item words in %0d runs, %0d of them overrunning the store.",
             words_sent, runs_closed, overflow_runs);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASS insertion_sorter");
    end else begin
      $display("FAIL insertion_sorter");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/isort_pkg.sv
rtl/core/isort_datapath.sv
rtl/core/isort_ctrl.sv
rtl/core/insertion_sorter.sv
rtl/core/isort_checker.sv
tb/sv/sorted_run_checker.sv
tb/sv/tb_insertion_sorter.sv
